@@ rtl/core/psfp_pkg.sv @@
// Shared constants and types for the particulate sensor frame parser.
// Used by psfp_parser, psfp_out_reg and particle_sensor_frame_parser_unit.
package psfp_pkg;

	localparam int FrameBytes = 32;
	localparam int SumBytes   = 30;
	localparam int ValueFirst = 4;
	localparam int ValueCount = 9;
	localparam int ValueW     = 16;
	localparam int PosW       = 6;
	localparam int IdxW       = $clog2(ValueCount);

	typedef logic [ValueCount-1:0][ValueW-1:0] values_t;

	typedef struct packed {
		logic    emit;
		values_t values;
		logic    ok;
	} result_t;

endpackage

@@ rtl/core/particle_sensor_frame_parser_unit.sv @@
// Particulate sensor frame parser: one frame byte per transaction in, one result per frame
// out after byte 31. A byte goes through an input register and the parser into the result
// register, which drives m_tvalid; one byte is taken every cycle unless the input stage
// stalls. The only stall is a finished result still waiting when the next byte 31 arrives.
// Depends on psfp_pkg, psfp_parser and psfp_out_reg.
module particle_sensor_frame_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] frame_start
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] pm1_mass, [31:16] pm25_mass, [47:32] pm10_mass, [63:48] count_over_0p3,
	// [79:64] count_over_0p5, [95:80] count_over_1p0, [111:96] count_over_2p5,
	// [127:112] count_over_5p0, [143:128] count_over_10
	output logic [143:0] m_tdata,
	output logic         m_tuser    // [0] checksum_ok
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;
	logic                 advance;
	logic                 out_free;
	psfp_pkg::result_t    result;

	// advance the held byte unless its result has nowhere to go
	assign advance  = valid_s1 && (!result.emit || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	psfp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1),
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.advance     (advance),
		.result      (result)
	);

	psfp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && result.emit),
		.result   (result),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef ASSERT_OFF
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.emit) |=> m_tvalid)
		else $error("loaded result not presented");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (result.emit && m_tvalid && !m_tready))
		else $error("input stage stalled without a blocked result");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input refused with empty input stage");
`endif

endmodule

@@ rtl/core/psfp_parser.sv @@
// Frame byte tracker: byte position, 16-bit running sum, value capture and checksum test.
// Depends on psfp_pkg.
module psfp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          data_byte,
	input  logic                frame_start,
	input  logic                advance,
	output psfp_pkg::result_t   result
);

	logic [psfp_pkg::PosW-1:0]   byte_pos_q;
	logic [15:0]                 sum_q;
	logic [7:0]                  hold_q;
	psfp_pkg::values_t           values_q;

	logic                        active;
	logic [psfp_pkg::PosW-1:0]   pos;
	logic [psfp_pkg::PosW-1:0]   rel;
	logic [psfp_pkg::IdxW-1:0]   idx;
	logic [15:0]                 sum_base;
	logic                        in_values;
	logic                        last_byte;

	always_comb begin
		active    = frame_start || (byte_pos_q < psfp_pkg::PosW'(psfp_pkg::FrameBytes));
		pos       = frame_start ? '0 : byte_pos_q;
		sum_base  = frame_start ? '0 : sum_q;
		rel       = pos - psfp_pkg::PosW'(psfp_pkg::ValueFirst);
		idx       = rel[psfp_pkg::IdxW:1];
		in_values = (pos >= psfp_pkg::PosW'(psfp_pkg::ValueFirst)) &&
			(pos < psfp_pkg::PosW'(psfp_pkg::ValueFirst + 2 * psfp_pkg::ValueCount));
		last_byte = (pos == psfp_pkg::PosW'(psfp_pkg::FrameBytes - 1));

		result.emit   = in_valid && active && last_byte;
		result.values = values_q;
		result.ok     = ({hold_q, data_byte} == sum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= psfp_pkg::PosW'(psfp_pkg::FrameBytes);
			sum_q      <= '0;
			hold_q     <= '0;
			values_q   <= '0;
		end else if (advance && active) begin
			if (pos < psfp_pkg::PosW'(psfp_pkg::SumBytes)) begin
				sum_q <= sum_base + 16'(data_byte);
			end else begin
				sum_q <= sum_base;
			end
			// even offset holds the high byte, odd offset completes the value
			if (in_values) begin
				if (!rel[0]) begin
					hold_q <= data_byte;
				end else begin
					values_q[idx] <= {hold_q, data_byte};
				end
			end else if (pos == psfp_pkg::PosW'(psfp_pkg::SumBytes)) begin
				hold_q <= data_byte;
			end
			if (last_byte) begin
				byte_pos_q <= psfp_pkg::PosW'(psfp_pkg::FrameBytes);
			end else begin
				byte_pos_q <= pos + 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/psfp_out_reg.sv @@
// Result register on the master side; holds one result until its transaction completes.
// Depends on psfp_pkg.
module psfp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  psfp_pkg::result_t   result,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [143:0]        m_tdata,
	output logic                m_tuser
);

	logic                 valid_q;
	psfp_pkg::values_t    values_q;
	logic                 ok_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = values_q;
	assign m_tuser  = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			values_q <= result.values;
			ok_q     <= result.ok;
		end
	end

endmodule
